// File: src/indexed_ordered_list_assert.svh
// Assertion macros shared by the list RTL.
// Each macro expects clk and rst_n in scope.
`ifndef INDEXED_ORDERED_LIST_ASSERT_SVH
`define INDEXED_ORDERED_LIST_ASSERT_SVH

// Same-cycle implication.
`define ILIST_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("indexed_ordered_list: assertion failed");

// Next-cycle implication.
`define ILIST_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("indexed_ordered_list: assertion failed");

`endif

// File: src/ilist_pkg.sv
package ilist_pkg;

  localparam int ILIST_CAPACITY   = 64;
  localparam int ILIST_VALUE_BITS = 32;

  // Signed compare width: covers indices up to the largest capacity and
  // move targets from -128 up to 127 + 127.
  localparam int CMD_W = 12;

  typedef enum logic [1:0] {
    KIND_INSERT = 2'd0,
    KIND_REMOVE = 2'd1,
    KIND_MOVE   = 2'd2,
    KIND_READ   = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    STS_OK         = 2'd0,
    STS_BAD_INDEX  = 2'd1,
    STS_BAD_TARGET = 2'd2,
    STS_FULL       = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    CM_HOLD   = 2'd0,
    CM_INSERT = 2'd1,
    CM_REMOVE = 2'd2,
    CM_MOVE   = 2'd3
  } cell_mode_t;

  // Broadcast to every cell of the chain.
  typedef struct packed {
    cell_mode_t              mode;
    logic signed [CMD_W-1:0] pos;
    logic signed [CMD_W-1:0] tgt;
  } cell_cmd_t;

endpackage

// File: src/ilist_cell.sv
module ilist_cell import ilist_pkg::*; #(
  parameter int VALUE_BITS = ILIST_VALUE_BITS,
  parameter int IDX        = 0
) (
  input  logic                  clk,
  input  cell_cmd_t             cmd,
  input  logic [VALUE_BITS-1:0] load_value,
  input  logic [VALUE_BITS-1:0] left_value,
  input  logic [VALUE_BITS-1:0] right_value,
  output logic [VALUE_BITS-1:0] value
);

  localparam logic signed [CMD_W-1:0] MY_IDX = CMD_W'(IDX);

  logic [VALUE_BITS-1:0] value_r;
  logic [VALUE_BITS-1:0] value_nxt;

  always_comb begin
    value_nxt = value_r;
    unique case (cmd.mode)
      CM_HOLD: value_nxt = value_r;
      CM_INSERT: begin
        if (MY_IDX == cmd.pos) begin
          value_nxt = load_value;
        end else if (MY_IDX > cmd.pos) begin
          value_nxt = left_value;
        end
      end
      CM_REMOVE: begin
        if (MY_IDX >= cmd.pos) begin
          value_nxt = right_value;
        end
      end
      CM_MOVE: begin
        // element travels from pos to tgt; cells between close up
        if (MY_IDX == cmd.tgt) begin
          value_nxt = load_value;
        end else if (cmd.tgt > cmd.pos && MY_IDX >= cmd.pos && MY_IDX < cmd.tgt) begin
          value_nxt = right_value;
        end else if (cmd.tgt < cmd.pos && MY_IDX > cmd.tgt && MY_IDX <= cmd.pos) begin
          value_nxt = left_value;
        end
      end
      default: value_nxt = value_r;
    endcase
  end

  always_ff @(posedge clk) begin
    value_r <= value_nxt;
  end

  assign value = value_r;

endmodule

// File: src/indexed_ordered_list.sv
// Steps per request: accept (while idle), fetch, apply; the result is registered onto
//   out_* by the apply step. A new request is taken only while idle; the fetch step
//   selects the addressed cell and registers it, the apply step shifts the chain.
// A finished result waiting on out_stall holds the apply step only.
// Reset (rst_n low at a clock edge): list becomes empty, no result pending,
//   cell contents are left as they are and never read before written.
`include "indexed_ordered_list_assert.svh"

module indexed_ordered_list import ilist_pkg::*; #(
  parameter int CAPACITY   = ILIST_CAPACITY,
  parameter int VALUE_BITS = ILIST_VALUE_BITS
) (
  input  logic               clk,
  input  logic               rst_n,

  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         in_kind,
  input  logic [6:0]         in_position,
  input  logic signed [31:0] in_item_value,
  input  logic signed [7:0]  in_offset,

  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] out_read_value,
  output logic [6:0]         out_list_length,
  output logic [1:0]         out_status
);

  localparam int CNT_W = $clog2(CAPACITY + 1);

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_FETCH = 3'b010,
    ST_APPLY = 3'b100
  } state_t;

  // ---------------------------------------------------------------------
  // Control and request registers
  // ---------------------------------------------------------------------
  state_t                  state_r, state_nxt;
  logic [CNT_W-1:0]        count_r, count_nxt;
  kind_t                   kind_r;
  status_t                 status_r;
  logic signed [CMD_W-1:0] pos_r;
  logic signed [CMD_W-1:0] tgt_r;
  logic [VALUE_BITS-1:0]   ival_r;
  logic [VALUE_BITS-1:0]   picked_r;

  logic                    out_valid_r;
  logic signed [31:0]      out_read_value_r;
  logic [6:0]              out_list_length_r;
  status_t                 out_status_r;

  // ---------------------------------------------------------------------
  // Request decode and range checks, done against the current length
  // while idle so the status is known before the chain is touched.
  // ---------------------------------------------------------------------
  logic                    in_accept;
  kind_t                   in_kind_e;
  logic signed [CMD_W-1:0] pos_e, cnt_e, off_e, tgt_e;
  status_t                 status_e;

  assign in_stall  = (state_r != ST_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign in_kind_e = kind_t'(in_kind);

  assign pos_e = CMD_W'(in_position);
  assign cnt_e = CMD_W'(count_r);
  assign off_e = CMD_W'(in_offset);
  assign tgt_e = pos_e + off_e;

  always_comb begin
    status_e = STS_OK;
    if (in_kind_e == KIND_INSERT) begin
      // index check comes ahead of the full check
      if (pos_e > cnt_e) begin
        status_e = STS_BAD_INDEX;
      end else if (cnt_e == CMD_W'(CAPACITY)) begin
        status_e = STS_FULL;
      end
    end else if (pos_e >= cnt_e) begin
      status_e = STS_BAD_INDEX;
    end else if (in_kind_e == KIND_MOVE) begin
      // target is a position in the list after the element is lifted out
      if (tgt_e < 0 || tgt_e >= cnt_e) begin
        status_e = STS_BAD_TARGET;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      kind_r   <= in_kind_e;
      status_r <= status_e;
      pos_r    <= pos_e;
      tgt_r    <= tgt_e;
      ival_r   <= VALUE_BITS'(in_item_value);
    end
  end

  // ---------------------------------------------------------------------
  // Cell chain
  // ---------------------------------------------------------------------
  logic [VALUE_BITS-1:0] cell_val [CAPACITY];
  cell_cmd_t             cmd;
  logic [VALUE_BITS-1:0] load_value;
  logic                  apply_go;

  // apply only once the output register is free (or being emptied)
  assign apply_go = (state_r == ST_APPLY) && !(out_valid_r && out_stall);

  always_comb begin
    cmd.mode = CM_HOLD;
    cmd.pos  = pos_r;
    cmd.tgt  = tgt_r;
    if (apply_go && status_r == STS_OK) begin
      unique case (kind_r)
        KIND_INSERT: cmd.mode = CM_INSERT;
        KIND_REMOVE: cmd.mode = CM_REMOVE;
        KIND_MOVE:   cmd.mode = CM_MOVE;
        KIND_READ:   cmd.mode = CM_HOLD;
        default:     cmd.mode = CM_HOLD;
      endcase
    end
  end

  assign load_value = (kind_r == KIND_INSERT) ? ival_r : picked_r;

  for (genvar gi = 0; gi < CAPACITY; gi++) begin : g_cell
    logic [VALUE_BITS-1:0] left_v;
    logic [VALUE_BITS-1:0] right_v;

    // end cells see themselves; their shifted-in contents lie past the length
    if (gi == 0) begin : g_first
      assign left_v = cell_val[gi];
    end else begin : g_left
      assign left_v = cell_val[gi-1];
    end
    if (gi == CAPACITY - 1) begin : g_last
      assign right_v = cell_val[gi];
    end else begin : g_right
      assign right_v = cell_val[gi+1];
    end

    ilist_cell #(
      .VALUE_BITS (VALUE_BITS),
      .IDX        (gi)
    ) u_cell (
      .clk         (clk),
      .cmd         (cmd),
      .load_value  (load_value),
      .left_value  (left_v),
      .right_value (right_v),
      .value       (cell_val[gi])
    );
  end

  // ---------------------------------------------------------------------
  // Fetch: AND-OR select of the addressed cell, registered
  // ---------------------------------------------------------------------
  logic [VALUE_BITS-1:0] pick;

  always_comb begin
    pick = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (CMD_W'(i) == pos_r) begin
        pick = pick | cell_val[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_FETCH) begin
      picked_r <= pick;
    end
  end

  // ---------------------------------------------------------------------
  // Sequencer and length
  // ---------------------------------------------------------------------
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:  if (in_accept) state_nxt = ST_FETCH;
      ST_FETCH: state_nxt = ST_APPLY;
      ST_APPLY: if (apply_go) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    count_nxt = count_r;
    if (status_r == STS_OK) begin
      if (kind_r == KIND_INSERT) begin
        count_nxt = count_r + CNT_W'(1);
      end else if (kind_r == KIND_REMOVE) begin
        count_nxt = count_r - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (apply_go) begin
        count_r <= count_nxt;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Output register
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (apply_go) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (apply_go) begin
      // insert and any error report a zero value
      if (status_r == STS_OK && kind_r != KIND_INSERT) begin
        out_read_value_r <= 32'(signed'(picked_r));
      end else begin
        out_read_value_r <= '0;
      end
      out_list_length_r <= 7'(count_nxt);
      out_status_r      <= status_r;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_read_value  = out_read_value_r;
  assign out_list_length = out_list_length_r;
  assign out_status      = out_status_r;

  // ---------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------
  `ILIST_ASSERT_NOW(a_count_bound, 1'b1, count_r <= CNT_W'(CAPACITY))
  `ILIST_ASSERT_NEXT(a_accept_fetch, in_accept, state_r == ST_FETCH)
  `ILIST_ASSERT_NOW(a_full_length, out_valid_r && out_status_r == STS_FULL, out_list_length_r == 7'(CAPACITY))
  `ILIST_ASSERT_NOW(a_error_zero, out_valid_r && out_status_r != STS_OK, out_read_value_r == 32'sd0)

endmodule

// File: bench/ilist_scoreboard_pkg.sv
`timescale 1ns / 100ps

package ilist_scoreboard_pkg;
  import ilist_pkg::*;

  typedef logic [ILIST_VALUE_BITS-1:0] cell_t;

  typedef struct {
    logic signed [31:0] value;
    logic [6:0]         length;
    status_t            status;
  } list_result_t;

  class list_scoreboard;
    cell_t        shadow_list[$];
    list_result_t pending_results[$];
    int           mismatches;
    int           results_checked;
    int           kind_count[4];
    int           status_count[4];
    int           longest;

    function int length();
      return shadow_list.size();
    endfunction

    function int outstanding();
      return pending_results.size();
    endfunction

    // Stored cell sign-extended from its own width, then cut to 32 bits.
    function logic signed [31:0] widen(cell_t c);
      logic signed [ILIST_VALUE_BITS-1:0] s;
      s = c;
      return 32'(s);
    endfunction

    // Apply one accepted request to the shadow list, queue its result.
    function void note_request(kind_t kind, logic [6:0] pos,
                               logic signed [31:0] item, logic signed [7:0] off);
      list_result_t result;
      cell_t        moved;
      int           target;
      result.value  = '0;
      result.status = STS_OK;
      kind_count[kind]++;
      if (kind == KIND_INSERT) begin
        if (int'(pos) > shadow_list.size()) begin
          result.status = STS_BAD_INDEX;
        end else if (shadow_list.size() >= ILIST_CAPACITY) begin
          result.status = STS_FULL;
        end else begin
          shadow_list.insert(int'(pos), cell_t'(item));
        end
      end else if (int'(pos) >= shadow_list.size()) begin
        result.status = STS_BAD_INDEX;
      end else begin
        case (kind)
          KIND_REMOVE: begin
            moved = shadow_list[pos];
            shadow_list.delete(int'(pos));
            result.value = widen(moved);
          end
          KIND_READ: begin
            result.value = widen(shadow_list[pos]);
          end
          default: begin
            target = int'(pos) + int'(off);
            if (target < 0 || target >= shadow_list.size()) begin
              result.status = STS_BAD_TARGET;
            end else begin
              moved = shadow_list[pos];
              shadow_list.delete(int'(pos));
              shadow_list.insert(target, moved);
              result.value = widen(moved);
            end
          end
        endcase
      end
      result.length = 7'(shadow_list.size());
      status_count[result.status]++;
      if (shadow_list.size() > longest) longest = shadow_list.size();
      pending_results.push_back(result);
    endfunction

    task report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      mismatches++;
      $display("[%0t] result %0d: %s got 0x%h, expected 0x%h",
               $time, results_checked, what, got, want);
    endtask

    task check_result(logic signed [31:0] value, logic [6:0] length,
                      logic [1:0] status);
      list_result_t want;
      if (pending_results.size() == 0) begin
        report_mismatch("result with no request outstanding, value", value, '0);
      end else begin
        want = pending_results.pop_front();
        if (value !== want.value)   report_mismatch("read_value", value, want.value);
        if (length !== want.length) report_mismatch("list_length", 32'(length),
                                                    32'(want.length));
        if (status !== want.status) report_mismatch("status", 32'(status),
                                                    32'(want.status));
      end
      results_checked++;
    endtask
  endclass

endpackage

// File: bench/indexed_ordered_list_test.sv
`timescale 1ns / 100ps

module indexed_ordered_list_test;
  import ilist_pkg::*;
  import ilist_scoreboard_pkg::*;

  // Cycles without any handshake on either channel before we call it a hang.
  // Worst legit quiet stretch is the long receiver hold-off plus a long
  // sender gap, so this leaves a wide margin.
  localparam int IDLE_LIMIT      = 4000;
  localparam int HOLD_OFF_CYCLES = 300;
  // Padding after the final drain, before the summary is printed.
  localparam int DRAIN_PAD       = 8;
  localparam int RANDOM_REQUESTS = 1950;

  logic               clk             = 1'b0;
  logic               rst_n           = 1'b0;
  logic               in_valid        = 1'b0;
  logic               in_stall;
  logic [1:0]         in_kind         = KIND_INSERT;
  logic [6:0]         in_position     = '0;
  logic signed [31:0] in_item_value   = '0;
  logic signed [7:0]  in_offset       = '0;
  logic               out_valid;
  logic               out_stall       = 1'b0;
  logic signed [31:0] out_read_value;
  logic [6:0]         out_list_length;
  logic [1:0]         out_status;

  // quiet_phase: neither side idles. hold_off_pending: sender asks the
  // receiver for one long stall.
  bit  quiet_phase      = 1'b0;
  bit  hold_off_pending = 1'b0;
  int  idle_cycles      = 0;

  list_scoreboard tracker = new();

  indexed_ordered_list i_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_kind         (in_kind),
    .in_position     (in_position),
    .in_item_value   (in_item_value),
    .in_offset       (in_offset),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_read_value  (out_read_value),
    .out_list_length (out_list_length),
    .out_status      (out_status)
  );

  always #10 clk = ~clk;

  // Idle cycles before the next request: mostly none or short, rarely long.
  function automatic int pick_gap();
    int r;
    if (quiet_phase) return 0;
    r = $urandom_range(99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Insert payload: extremes now and then so the sign bit and all-ones show up.
  function automatic logic signed [31:0] pick_value();
    case ($urandom_range(19))
      0:       return 32'sh8000_0000;
      1:       return 32'sh7fff_ffff;
      2:       return '0;
      3:       return '1;
      default: return $urandom;
    endcase
  endfunction

  // Present one request, hold it until the block takes it, then record it.
  // Within this task valid is only lowered on a gap, so back-to-back requests keep it high.
  task automatic send_request(kind_t kind, logic [6:0] pos,
                              logic signed [31:0] value, logic signed [7:0] off);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_kind       <= kind;
    in_position   <= pos;
    in_item_value <= value;
    in_offset     <= off;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    tracker.note_request(kind, pos, value, off);
  endtask

  // Sender goes quiet until every outstanding result has been checked.
  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (tracker.outstanding() != 0);
  endtask

  // One random request shaped by the current list length.
  //   insert_pct: share of inserts (the rest split among remove/move/read)
  //   stray_pct:  share of positions drawn from the whole 7-bit range
  task automatic send_random(int insert_pct, int stray_pct);
    int               len;
    int               target;
    kind_t            kind;
    logic [6:0]       pos;
    logic signed [7:0] off;
    len = tracker.length();
    if ($urandom_range(99) < insert_pct) begin
      kind = KIND_INSERT;
    end else begin
      case ($urandom_range(2))
        0:       kind = KIND_REMOVE;
        1:       kind = KIND_MOVE;
        default: kind = KIND_READ;
      endcase
    end
    if ($urandom_range(99) < stray_pct) begin
      pos = 7'($urandom_range(127));
    end else if (kind == KIND_INSERT) begin
      pos = 7'($urandom_range(len));
    end else begin
      pos = 7'($urandom_range(len > 0 ? len - 1 : 0));
    end
    // Full 8-bit offset by default; most moves get an in-range target instead.
    off = 8'($urandom);
    if (kind == KIND_MOVE && len > 0 && $urandom_range(99) < 80) begin
      target = $urandom_range(len - 1);
      off    = 8'(target - int'(pos));
    end
    send_request(kind, pos, pick_value(), off);
  endtask

  // Result side: only accepted results are checked.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      tracker.check_result(out_read_value, out_list_length, out_status);
  end

  // Hang detector: any handshake resets the count.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("timeout: no handshake for %0d cycles, %0d results outstanding",
               IDLE_LIMIT, tracker.outstanding());
      $display("FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Receiver: random open/stall windows, none in quiet phases, and one long
  // hold-off on request so the block backs up and stalls its input.
  initial begin
    int open_len;
    int hold_len;
    @(posedge clk);
    forever begin
      if (hold_off_pending) begin
        hold_off_pending = 1'b0;
        out_stall <= 1'b1;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
      end else if (quiet_phase) begin
        out_stall <= 1'b0;
        @(posedge clk);
      end else begin
        open_len = $urandom_range(1, 8);
        hold_len = ($urandom_range(9) == 0) ? $urandom_range(15, 50)
                                            : $urandom_range(0, 3);
        out_stall <= 1'b0;
        repeat (open_len) @(posedge clk);
        if (hold_len > 0) begin
          out_stall <= 1'b1;
          repeat (hold_len) @(posedge clk);
        end
      end
    end
  end

  initial begin
    int sent;
    int phase;
    int span;
    int insert_pct;
    int stray_pct;

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Empty list: every access is out of range, insert past the end too.
    send_request(KIND_READ,   7'd0, '0, 8'sd0);
    send_request(KIND_REMOVE, 7'd0, '0, 8'sd0);
    send_request(KIND_MOVE,   7'd0, '0, 8'sd0);
    send_request(KIND_INSERT, 7'd1, 32'sd5, 8'sd0);
    // Build [min, 0, max, -1] through front, end and middle inserts.
    send_request(KIND_INSERT, 7'd0, 32'sh7fff_ffff, 8'sd0);
    send_request(KIND_INSERT, 7'd0, 32'sh8000_0000, 8'sd0);
    send_request(KIND_INSERT, 7'd2, -32'sd1, 8'sd0);
    send_request(KIND_INSERT, 7'd1, 32'sd0, 8'sd0);
    send_request(KIND_READ,   7'd0, '0, 8'sd0);
    send_request(KIND_READ,   7'd3, '0, 8'sd0);
    // Top of the position field, and a position equal to the length.
    send_request(KIND_READ,   7'd127, '0, 8'sd0);
    send_request(KIND_REMOVE, 7'd4, '0, 8'sd0);
    // Moves to both ends and back.
    send_request(KIND_MOVE,   7'd0, '0, 8'sd3);
    send_request(KIND_MOVE,   7'd3, '0, -8'sd3);
    // Move targets just outside and far outside the list, then a move onto its own position.
    send_request(KIND_MOVE,   7'd0, '0, -8'sd1);
    send_request(KIND_MOVE,   7'd3, '0, 8'sd1);
    send_request(KIND_MOVE,   7'd1, '0, 8'sd64);
    send_request(KIND_MOVE,   7'd2, '0, -8'sd64);
    send_request(KIND_MOVE,   7'd1, '0, 8'sd0);
    // Remove from the end, front, end again, then the only element left.
    send_request(KIND_REMOVE, 7'd3, '0, 8'sd0);
    send_request(KIND_REMOVE, 7'd0, '0, 8'sd0);
    send_request(KIND_REMOVE, 7'd1, '0, 8'sd0);
    send_request(KIND_REMOVE, 7'd0, '0, 8'sd0);
    send_request(KIND_READ,   7'd0, '0, 8'sd0);
    send_request(KIND_INSERT, 7'd0, 32'sh5a5a_5a5a, 8'sd0);
    wait_drained();

    // Random phases. The first one climbs to a full list; later phases mix
    // climbing, shrinking, balanced traffic and stray positions. Phase 3 is
    // the back-pressure burst; every sixth phase ends with a full drain.
    sent  = 0;
    phase = 0;
    while (sent < RANDOM_REQUESTS) begin
      quiet_phase = ($urandom_range(4) == 0);
      stray_pct   = 8;
      case ($urandom_range(3))
        0:       insert_pct = 80;
        1:       insert_pct = 15;
        2:       insert_pct = 40;
        default: begin
          insert_pct = 40;
          stray_pct  = 50;
        end
      endcase
      span = $urandom_range(40, 120);
      if (phase == 0) begin
        insert_pct = 85;
        span       = 120;
      end
      if (phase == 3) begin
        quiet_phase      = 1'b1;
        hold_off_pending = 1'b1;
      end
      repeat (span) send_random(insert_pct, stray_pct);
      sent += span;
      if (phase % 6 == 5) wait_drained();
      phase++;
    end
    quiet_phase = 1'b0;

    wait_drained();
    repeat (DRAIN_PAD) @(posedge clk);

    $display("ran %0d requests: %0d insert, %0d remove, %0d move, %0d read; %0d results checked",
             tracker.kind_count[KIND_INSERT] + tracker.kind_count[KIND_REMOVE] +
             tracker.kind_count[KIND_MOVE] + tracker.kind_count[KIND_READ],
             tracker.kind_count[KIND_INSERT], tracker.kind_count[KIND_REMOVE],
             tracker.kind_count[KIND_MOVE], tracker.kind_count[KIND_READ],
             tracker.results_checked);
    $display("outcomes: %0d ok, %0d bad index, %0d bad target, %0d full; longest list %0d",
             tracker.status_count[STS_OK], tracker.status_count[STS_BAD_INDEX],
             tracker.status_count[STS_BAD_TARGET], tracker.status_count[STS_FULL],
             tracker.longest);
    if (tracker.mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
